[hdl/obn_pkg.sv]
package obn_pkg;

    // Result format: signed Q1.(OUT_FRAC), so 1.0 is 2**OUT_FRAC.
    localparam int OUT_FRAC = 30;
    localparam int COMP_W   = 32;
    // Residual vectors in Q(2*OUT_FRAC) and the sign-extended input share one width.
    localparam int W_W      = 64;
    // The largest magnitude after the normalizing shift lies in [2**(M_W-1), 2**M_W).
    localparam int M_W      = 31;

    localparam int SHIFT_STAGES = 6;
    localparam int SQ_STEPS     = 32;
    localparam int ROOT_W       = 32;
    localparam int SQ_REM_W     = ROOT_W + 2;
    localparam int DIV_STEPS    = OUT_FRAC + 1;
    localparam int DIV_REM_W    = ROOT_W;

    // Stage indexes inside one normalizer.
    localparam int ST_Q       = SHIFT_STAGES + 1;
    localparam int ST_SUM     = ST_Q + 1;
    localparam int ST_DIV0    = ST_SUM + SQ_STEPS;
    localparam int ST_OUT     = ST_DIV0 + DIV_STEPS + 1;
    localparam int NORM_DEPTH = ST_OUT + 1;

    typedef enum logic [1:0] {
        AX_X,
        AX_Y,
        AX_Z
    } t_axis;

    typedef logic signed [COMP_W-1:0] t_comp;
    typedef t_comp [2:0] t_vec;
    typedef logic signed [W_W-1:0] t_wide;
    typedef t_wide [2:0] t_wvec;

    typedef struct packed {
        logic  zero_in;
        t_axis ax2;
        t_axis ax3;
        t_vec  e1;
        t_vec  e2;
    } t_side;

    typedef struct packed {
        logic       valid;
        logic       zero;
        logic [2:0] neg;
        t_side      side;
    } t_ctl;

    localparam t_comp ONE  = t_comp'(64'sd1 <<< OUT_FRAC);
    localparam t_wide ONE2 = t_wide'(64'sd1 <<< (2 * OUT_FRAC));

    function automatic t_comp pick(input t_vec v, input t_axis a);
        t_comp r;
        case (a)
            AX_X:    r = v[0];
            AX_Y:    r = v[1];
            AX_Z:    r = v[2];
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

[hdl/obn_sqrt_cell.sv]
module obn_sqrt_cell (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [obn_pkg::SQ_REM_W-1:0]   i_rem,
    input  logic [obn_pkg::W_W-1:0]        i_rad,
    input  logic [obn_pkg::ROOT_W-1:0]     i_root,
    output logic [obn_pkg::SQ_REM_W-1:0]   o_rem,
    output logic [obn_pkg::W_W-1:0]        o_rad,
    output logic [obn_pkg::ROOT_W-1:0]     o_root
);
    import obn_pkg::*;

    logic [SQ_REM_W+1:0] w_sh;
    logic [SQ_REM_W+1:0] w_trial;
    logic [SQ_REM_W+1:0] w_diff;
    logic                w_take;
    logic [SQ_REM_W-1:0] n_rem;
    logic [SQ_REM_W-1:0] r_rem;
    logic [W_W-1:0]      r_rad;
    logic [ROOT_W-1:0]   r_root;

    // One root bit per cell: bring in two radicand bits, try root*4+1.
    assign w_sh    = {i_rem, i_rad[W_W-1 -: 2]};
    assign w_trial = (SQ_REM_W + 2)'({i_root, 2'b01});
    assign w_diff  = w_sh - w_trial;
    assign w_take  = (w_sh >= w_trial);
    assign n_rem   = w_take ? w_diff[SQ_REM_W-1:0] : w_sh[SQ_REM_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_rad  <= i_rad << 2;
            r_root <= {i_root[ROOT_W-2:0], w_take};
        end
    end

    assign o_rem  = r_rem;
    assign o_rad  = r_rad;
    assign o_root = r_root;

endmodule

[hdl/obn_div_cell.sv]
module obn_div_cell (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [obn_pkg::DIV_REM_W-1:0]  i_rem,
    input  logic [obn_pkg::DIV_STEPS-1:0]  i_feed,
    input  logic [obn_pkg::DIV_STEPS-1:0]  i_q,
    input  logic [obn_pkg::ROOT_W-1:0]     i_den,
    output logic [obn_pkg::DIV_REM_W-1:0]  o_rem,
    output logic [obn_pkg::DIV_STEPS-1:0]  o_feed,
    output logic [obn_pkg::DIV_STEPS-1:0]  o_q,
    output logic [obn_pkg::ROOT_W-1:0]     o_den
);
    import obn_pkg::*;

    logic [DIV_REM_W:0]   w_sh;
    logic [DIV_REM_W:0]   w_diff;
    logic                 w_take;
    logic [DIV_REM_W-1:0] r_rem;
    logic [DIV_STEPS-1:0] r_feed;
    logic [DIV_STEPS-1:0] r_q;
    logic [ROOT_W-1:0]    r_den;

    // One quotient bit per cell of a restoring division.
    assign w_sh   = {i_rem, i_feed[DIV_STEPS-1]};
    assign w_diff = w_sh - (DIV_REM_W + 1)'(i_den);
    assign w_take = (w_sh >= (DIV_REM_W + 1)'(i_den));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= w_take ? w_diff[DIV_REM_W-1:0] : w_sh[DIV_REM_W-1:0];
            r_feed <= i_feed << 1;
            r_q    <= {i_q[DIV_STEPS-2:0], w_take};
            r_den  <= i_den;
        end
    end

    assign o_rem  = r_rem;
    assign o_feed = r_feed;
    assign o_q    = r_q;
    assign o_den  = r_den;

endmodule

[hdl/obn_norm.sv]
module obn_norm (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  obn_pkg::t_wvec i_w,
    input  obn_pkg::t_side i_side,
    output logic           o_valid,
    output obn_pkg::t_vec  o_e,
    output obn_pkg::t_side o_side
);
    import obn_pkg::*;

    t_ctl                 r_ctl [NORM_DEPTH];
    t_ctl                 n_ctl [NORM_DEPTH];
    logic [W_W-1:0]       r_mag [SHIFT_STAGES+1][3];
    logic [M_W-1:0]       r_m   [ST_Q:ST_DIV0][3];
    logic [2*M_W-1:0]     r_sq  [3];
    logic [W_W-1:0]       r_s;
    logic [M_W-1:0]       w_m   [3];
    logic                 w_zero;
    t_vec                 r_e;
    t_vec                 n_e;

    logic [SQ_REM_W-1:0]  w_sq_rem  [SQ_STEPS+1];
    logic [W_W-1:0]       w_sq_rad  [SQ_STEPS+1];
    logic [ROOT_W-1:0]    w_sq_root [SQ_STEPS+1];

    logic [DIV_REM_W-1:0] w_dv_rem  [3][DIV_STEPS+1];
    logic [DIV_STEPS-1:0] w_dv_feed [3][DIV_STEPS+1];
    logic [DIV_STEPS-1:0] w_dv_q    [3][DIV_STEPS+1];
    logic [ROOT_W-1:0]    w_dv_den  [3][DIV_STEPS+1];

    // Control travels alongside the data; the zero flag is set after the shifts.
    always_comb begin
        n_ctl[0].valid = i_valid;
        n_ctl[0].zero  = 1'b0;
        n_ctl[0].neg   = {i_w[2][W_W-1], i_w[1][W_W-1], i_w[0][W_W-1]};
        n_ctl[0].side  = i_side;
        for (int k = 1; k < NORM_DEPTH; k++) begin
            n_ctl[k] = r_ctl[k-1];
        end
        n_ctl[ST_Q].zero = w_zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '{default: '0};
        end else if (i_en) begin
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_mag[0][i] <= i_w[i][W_W-1] ? W_W'(-i_w[i]) : W_W'(i_w[i]);
            end
        end
    end

    // Leading-bit search in halving steps: the largest magnitude ends with bit 63 set.
    for (genvar k = 0; k < SHIFT_STAGES; k++) begin : g_shift
        localparam int AMT = (W_W / 2) >> k;
        logic [W_W-1:0] w_or;
        logic           w_lz;
        assign w_or = r_mag[k][0] | r_mag[k][1] | r_mag[k][2];
        assign w_lz = (w_or[W_W-1 -: AMT] == '0);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int i = 0; i < 3; i++) begin
                    r_mag[k+1][i] <= w_lz ? (r_mag[k][i] << AMT) : r_mag[k][i];
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_m[i] = r_mag[SHIFT_STAGES][i][W_W-1 -: M_W];
        end
        w_zero = ((w_m[0] | w_m[1] | w_m[2]) == '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_m[ST_Q][i] <= w_m[i];
                r_sq[i]      <= (2 * M_W)'(w_m[i]) * (2 * M_W)'(w_m[i]);
            end
            r_s <= W_W'(r_sq[0]) + W_W'(r_sq[1]) + W_W'(r_sq[2]);
            for (int k = ST_Q + 1; k <= ST_DIV0; k++) begin
                r_m[k] <= r_m[k-1];
            end
        end
    end

    assign w_sq_rem[0]  = '0;
    assign w_sq_rad[0]  = r_s;
    assign w_sq_root[0] = '0;

    for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
        obn_sqrt_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (i_en),
            .i_rem  (w_sq_rem[j]),
            .i_rad  (w_sq_rad[j]),
            .i_root (w_sq_root[j]),
            .o_rem  (w_sq_rem[j+1]),
            .o_rad  (w_sq_rad[j+1]),
            .o_root (w_sq_root[j+1])
        );
    end

    for (genvar i = 0; i < 3; i++) begin : g_lane
        assign w_dv_rem[i][0]  = DIV_REM_W'(r_m[ST_DIV0][i] >> 1);
        assign w_dv_feed[i][0] = {r_m[ST_DIV0][i][0], (DIV_STEPS - 1)'(0)};
        assign w_dv_q[i][0]    = '0;
        assign w_dv_den[i][0]  = w_sq_root[SQ_STEPS];
        for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
            obn_div_cell u_cell (
                .i_clk  (i_clk),
                .i_en   (i_en),
                .i_rem  (w_dv_rem[i][j]),
                .i_feed (w_dv_feed[i][j]),
                .i_q    (w_dv_q[i][j]),
                .i_den  (w_dv_den[i][j]),
                .o_rem  (w_dv_rem[i][j+1]),
                .o_feed (w_dv_feed[i][j+1]),
                .o_q    (w_dv_q[i][j+1]),
                .o_den  (w_dv_den[i][j+1])
            );
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_ctl[ST_OUT-1].zero) begin
                n_e[i] = '0;
            end else if (r_ctl[ST_OUT-1].neg[i]) begin
                n_e[i] = -t_comp'(w_dv_q[i][DIV_STEPS]);
            end else begin
                n_e[i] = t_comp'(w_dv_q[i][DIV_STEPS]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e <= n_e;
        end
    end

    assign o_valid = r_ctl[ST_OUT].valid;
    assign o_e     = r_e;
    assign o_side  = r_ctl[ST_OUT].side;

    a_shift_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl[ST_Q].valid && !r_ctl[ST_Q].zero
        |-> (r_m[ST_Q][0][M_W-1] | r_m[ST_Q][1][M_W-1] | r_m[ST_Q][2][M_W-1]))
        else $error("normalized magnitudes lost their leading bit");

    a_root_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl[ST_DIV0].valid && !r_ctl[ST_DIV0].zero
        |-> (w_sq_root[SQ_STEPS][ROOT_W-1 -: 2] != 2'b00))
        else $error("square root below the normalized range");

    a_quot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl[ST_OUT-1].valid && !r_ctl[ST_OUT-1].zero
        |-> (w_dv_q[0][DIV_STEPS] <= DIV_STEPS'(ONE))
            && (w_dv_q[1][DIV_STEPS] <= DIV_STEPS'(ONE))
            && (w_dv_q[2][DIV_STEPS] <= DIV_STEPS'(ONE)))
        else $error("unit component quotient exceeds one");

endmodule

[hdl/orthonormal_basis_3d_unit.sv]
// Orthonormal basis from one 3D vector.
// Input channel: i_valid / o_stall with the vector i_in_x, i_in_y, i_in_z in
// signed Q16.16. A transfer happens at a rising edge with i_valid high and
// o_stall low. Output channel: o_valid / i_stall with nine signed Q1.30
// components; the first vector is the input normalized, the other two come
// from Gram-Schmidt on the unit seeds, and a zero input gives the identity.
// Throughput is one vector per cycle while the receiver does not stall. The
// path holds 224 register stages: three normalizers of 73 stages each
// (magnitude, six shift stages, squares, sum, a 32-cell square-root chain,
// three 31-cell divider chains and the result register), two product and
// subtract stages before each of the second and third normalizers, and the
// output register.
// When the receiver stalls a waiting result, the whole pipeline holds and
// o_stall rises in the same cycle; in-flight items keep their place and
// nothing is dropped. Synchronous reset (i_rst_n low) empties the pipeline
// and clears o_valid; no clearing pass is needed afterwards.
module orthonormal_basis_3d_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  obn_pkg::t_comp i_in_x,
    input  obn_pkg::t_comp i_in_y,
    input  obn_pkg::t_comp i_in_z,
    output logic          o_valid,
    input  logic          i_stall,
    output obn_pkg::t_comp o_first_x,
    output obn_pkg::t_comp o_first_y,
    output obn_pkg::t_comp o_first_z,
    output obn_pkg::t_comp o_second_x,
    output obn_pkg::t_comp o_second_y,
    output obn_pkg::t_comp o_second_z,
    output obn_pkg::t_comp o_third_x,
    output obn_pkg::t_comp o_third_y,
    output obn_pkg::t_comp o_third_z
);
    import obn_pkg::*;

    // Pipeline advance: moves whenever the output register is empty or being taken.
    logic  w_en;

    t_wvec w_in_w;
    t_side w_in_side;

    logic  w_v1;
    t_vec  w_e1;
    t_side w_side1;
    logic  w_v2;
    t_vec  w_e2;
    t_side w_side2;
    logic  w_v3;
    t_vec  w_e3;
    t_side w_side3;

    // Side data with the freshly built basis vector folded in.
    t_side w_g2_side;
    t_side w_g3_side;

    // Second-vector residual stages.
    logic  r_g2a_valid;
    t_wvec r_g2a_p;
    t_side r_g2a_side;
    logic  r_g2b_valid;
    t_wvec r_g2b_w;
    t_side r_g2b_side;

    // Third-vector residual stages.
    logic  r_g3a_valid;
    t_wvec r_g3a_pa;
    t_wvec r_g3a_pb;
    t_side r_g3a_side;
    logic  r_g3b_valid;
    t_wvec r_g3b_w;
    t_side r_g3b_side;

    logic  r_out_valid;
    t_vec  r_first;
    t_vec  r_second;
    t_vec  r_third;

    assign w_en    = !(r_out_valid && i_stall);
    assign o_stall = !w_en;

    // Seed choice: j,k normally; i,k when x is zero; i,j when x and y are zero.
    always_comb begin
        w_in_w[0] = t_wide'(i_in_x);
        w_in_w[1] = t_wide'(i_in_y);
        w_in_w[2] = t_wide'(i_in_z);
        w_in_side         = '0;
        w_in_side.zero_in = (i_in_x == '0) && (i_in_y == '0) && (i_in_z == '0);
        w_in_side.ax2     = AX_Y;
        w_in_side.ax3     = AX_Z;
        if (i_in_x == '0) begin
            w_in_side.ax2 = AX_X;
            if (i_in_y == '0) begin
                w_in_side.ax3 = AX_Y;
            end
        end
    end

    obn_norm u_norm1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_w     (w_in_w),
        .i_side  (w_in_side),
        .o_valid (w_v1),
        .o_e     (w_e1),
        .o_side  (w_side1)
    );

    always_comb begin
        w_g2_side    = w_side1;
        w_g2_side.e1 = w_e1;
    end

    // w2 = s2 - (s2.e1) e1, where s2.e1 is e1's component on the seed axis.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g2a_valid <= 1'b0;
            r_g2b_valid <= 1'b0;
        end else if (w_en) begin
            r_g2a_valid <= w_v1;
            r_g2b_valid <= r_g2a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_g2a_p[i] <= t_wide'(pick(w_e1, w_side1.ax2)) * t_wide'(w_e1[i]);
                r_g2b_w[i] <= ((t_axis'(i) == r_g2a_side.ax2) ? ONE2 : t_wide'(0))
                              - r_g2a_p[i];
            end
            r_g2a_side <= w_g2_side;
            r_g2b_side <= r_g2a_side;
        end
    end

    obn_norm u_norm2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_g2b_valid),
        .i_w     (r_g2b_w),
        .i_side  (r_g2b_side),
        .o_valid (w_v2),
        .o_e     (w_e2),
        .o_side  (w_side2)
    );

    always_comb begin
        w_g3_side    = w_side2;
        w_g3_side.e2 = w_e2;
    end

    // w3 = s3 - (s3.e2) e2 - (s3.e1) e1, both dot products taken from the seed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g3a_valid <= 1'b0;
            r_g3b_valid <= 1'b0;
        end else if (w_en) begin
            r_g3a_valid <= w_v2;
            r_g3b_valid <= r_g3a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_g3a_pa[i] <= t_wide'(pick(w_e2, w_side2.ax3)) * t_wide'(w_e2[i]);
                r_g3a_pb[i] <= t_wide'(pick(w_side2.e1, w_side2.ax3))
                               * t_wide'(w_side2.e1[i]);
                r_g3b_w[i]  <= ((t_axis'(i) == r_g3a_side.ax3) ? ONE2 : t_wide'(0))
                               - r_g3a_pa[i] - r_g3a_pb[i];
            end
            r_g3a_side <= w_g3_side;
            r_g3b_side <= r_g3a_side;
        end
    end

    obn_norm u_norm3 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_g3b_valid),
        .i_w     (r_g3b_w),
        .i_side  (r_g3b_side),
        .o_valid (w_v3),
        .o_e     (w_e3),
        .o_side  (w_side3)
    );

    // Output register; a zero input is replaced by the identity basis here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_side3.zero_in) begin
                r_first  <= '{'0, '0, ONE};
                r_second <= '{'0, ONE, '0};
                r_third  <= '{ONE, '0, '0};
            end else begin
                r_first  <= w_side3.e1;
                r_second <= w_side3.e2;
                r_third  <= w_e3;
            end
        end
    end

    assign o_valid    = r_out_valid;
    assign o_first_x  = r_first[0];
    assign o_first_y  = r_first[1];
    assign o_first_z  = r_first[2];
    assign o_second_x = r_second[0];
    assign o_second_y = r_second[1];
    assign o_second_z = r_second[2];
    assign o_third_x  = r_third[0];
    assign o_third_y  = r_third[1];
    assign o_third_z  = r_third[2];

    // The diagonal components (first x, second y, third z) of a delivered basis stay within plus or minus one.
    a_unit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_first_x <= ONE) && (o_first_x >= -ONE)
                 && (o_second_y <= ONE) && (o_second_y >= -ONE)
                 && (o_third_z <= ONE) && (o_third_z >= -ONE))
        else $error("basis component outside the unit range");

endmodule
